@@ design/h264_rtp_fu_a_packetizer_macros.svh @@
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer assertion macros
// Shared assertion forms on clk with the asynchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef H264_RTP_FU_A_PACKETIZER_MACROS_SVH
`define H264_RTP_FU_A_PACKETIZER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define H264FUA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define H264FUA_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ design/h264fua_pkg.sv @@
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer package
// Field widths, RTP/FU-A header constants and the result word type.
// ----------------------------------------------------------------------------
package h264fua_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int TS_W   = 32;
    localparam int PAY_W  = 16;

    localparam logic [BYTE_W-1:0] NRI_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] FU_A_TYPE = 8'd28;
    localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] START_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] END_BIT   = 8'h40;

    localparam logic [PAY_W-1:0] MIN_PAYLOAD   = 16'd4;
    localparam logic [PAY_W-1:0] RESET_PAYLOAD = 16'd1400;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              packet_start;
        logic              packet_end;
        logic              marker;
        logic [TS_W-1:0]   packet_timestamp;
    } res_t;

endpackage

@@ design/h264fua_if.sv @@
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer channels
// Valid/ready channels for NAL byte words and RTP payload byte words.
// ----------------------------------------------------------------------------
interface h264fua_in_if;
    logic                           valid;
    logic                           ready;
    logic [h264fua_pkg::BYTE_W-1:0] nal_byte;
    logic [h264fua_pkg::LEN_W-1:0]  nal_length;
    logic                           last_nal_in_unit;
    logic [h264fua_pkg::TS_W-1:0]   timestamp;

    modport source (output valid, nal_byte, nal_length, last_nal_in_unit, timestamp,
                    input ready);
    modport sink   (input valid, nal_byte, nal_length, last_nal_in_unit, timestamp,
                    output ready);
endinterface

interface h264fua_out_if;
    logic                           valid;
    logic                           ready;
    logic [h264fua_pkg::BYTE_W-1:0] out_byte;
    logic                           packet_start;
    logic                           packet_end;
    logic                           marker;
    logic [h264fua_pkg::TS_W-1:0]   packet_timestamp;

    modport source (output valid, out_byte, packet_start, packet_end, marker,
                    packet_timestamp, input ready);
    modport sink   (input valid, out_byte, packet_start, packet_end, marker,
                    packet_timestamp, output ready);
endinterface

@@ design/h264_rtp_fu_a_packetizer.sv @@
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer
// Builds RTP payload bytes from NAL bytes, single-NAL or FU-A fragmented.
// ----------------------------------------------------------------------------
// The block takes one NAL byte per cycle and gives one payload byte per
// cycle while the output is not stalled. A NAL byte gives one payload byte,
// except the byte that opens an FU-A fragment, which gives three because
// the FU indicator and FU header are sent ahead of it from the same held
// input word; the header byte of a fragmented NAL and an empty NAL give
// nothing. Each byte passes an input register and then an output register.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    h264fua_in_if.sink                    nal,
    h264fua_out_if.source                 pkt,
    input  logic                          cfg_we,
    input  logic [h264fua_pkg::PAY_W-1:0] cfg_wdata
);

    h264fua_pkg::res_t res;
    logic              res_valid;
    logic              res_ready;

    h264fua_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .nal       (nal),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    h264fua_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pkt       (pkt)
    );

endmodule

@@ design/h264fua_core.sv @@
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer core
// Input register, NAL/fragment state and per-word result selection.
// ----------------------------------------------------------------------------
module h264fua_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    h264fua_in_if.sink                      nal,
    input  logic                            cfg_we,
    input  logic [h264fua_pkg::PAY_W-1:0]   cfg_wdata,
    output h264fua_pkg::res_t               res,
    output logic                            res_valid,
    input  logic                            res_ready
);

`include "h264_rtp_fu_a_packetizer_macros.svh"

    localparam int LB = LENGTH_BITS;
    localparam int CW = (LENGTH_BITS > h264fua_pkg::PAY_W) ? LENGTH_BITS : h264fua_pkg::PAY_W;
    localparam int PW = h264fua_pkg::PAY_W;

    typedef enum logic [1:0] {
        PH_IND,
        PH_HDR,
        PH_BYTE
    } phase_t;

    localparam logic [LB:0] ONE_X = (LB+1)'(1);
    localparam logic [PW:0] ONE_F = (PW+1)'(1);

    // Held input word.
    logic                                item_valid_reg;
    logic [h264fua_pkg::BYTE_W-1:0]      item_byte_reg;
    logic [h264fua_pkg::LEN_W-1:0]       item_len_reg;
    logic                                item_last_reg;
    logic [h264fua_pkg::TS_W-1:0]        item_ts_reg;

    // Packetizer state.
    logic [PW-1:0]                       max_reg;
    logic [LB-1:0]                       bp_reg, bp_next;
    logic [LB-1:0]                       total_reg, total_next;
    logic                                frag_reg, frag_next;
    logic [PW-1:0]                       fill_reg, fill_next;
    logic [h264fua_pkg::BYTE_W-1:0]      hdr_reg, hdr_next;
    logic                                last_reg, last_next;
    logic                                first_reg, first_next;
    phase_t                              phase_reg, phase_next;

    logic [LB-1:0]                       len_lb;
    logic [PW-1:0]                       cap;
    logic [LB-1:0]                       remaining;
    logic                                nal_end;
    logic                                frag_end;
    logic                                has_result;
    phase_t                              last_phase;
    logic                                out_fire;
    logic                                item_done;
    logic [h264fua_pkg::BYTE_W-1:0]      fu_hdr;

    assign len_lb    = LB'(item_len_reg);
    assign cap       = max_reg - PW'(2);
    assign remaining = total_reg - bp_reg;
    assign nal_end   = ({1'b0, bp_reg} + ONE_X) >= {1'b0, total_reg};
    assign frag_end  = nal_end || (({1'b0, fill_reg} + ONE_F) >= {1'b0, cap});

    always_comb
    begin
        fu_hdr = hdr_reg & h264fua_pkg::TYPE_MASK;
        if (first_reg)
        begin
            fu_hdr = fu_hdr | h264fua_pkg::START_BIT;
        end
        if (CW'(remaining) <= CW'(cap))
        begin
            fu_hdr = fu_hdr | h264fua_pkg::END_BIT;
        end
    end

    // Result selection and the state that the held word leaves behind.
    always_comb
    begin
        has_result                  = 1'b1;
        last_phase                  = PH_IND;
        res.out_byte                = item_byte_reg;
        res.packet_start            = 1'b0;
        res.packet_end              = 1'b0;
        res.marker                  = 1'b0;
        res.packet_timestamp        = item_ts_reg;
        bp_next    = bp_reg;
        total_next = total_reg;
        frag_next  = frag_reg;
        fill_next  = fill_reg;
        hdr_next   = hdr_reg;
        last_next  = last_reg;
        first_next = first_reg;

        if (bp_reg == '0)
        begin
            if (len_lb == '0)
            begin
                // An empty NAL is dropped without effect.
                has_result = 1'b0;
            end
            else if (CW'(len_lb) > CW'(max_reg))
            begin
                // The header of a fragmented NAL is swallowed.
                has_result = 1'b0;
                total_next = len_lb;
                last_next  = item_last_reg;
                frag_next  = 1'b1;
                hdr_next   = item_byte_reg;
                first_next = 1'b1;
                fill_next  = '0;
                bp_next    = LB'(1);
            end
            else
            begin
                total_next         = len_lb;
                last_next          = item_last_reg;
                frag_next          = 1'b0;
                res.packet_start   = 1'b1;
                res.packet_end     = (len_lb == LB'(1));
                res.marker         = (len_lb == LB'(1)) && item_last_reg;
                bp_next            = (len_lb == LB'(1)) ? '0 : LB'(1);
            end
        end
        else if (!frag_reg)
        begin
            res.packet_end = nal_end;
            res.marker     = nal_end && last_reg;
            bp_next        = nal_end ? '0 : bp_reg + LB'(1);
        end
        else
        begin
            if (fill_reg == '0)
            begin
                last_phase = PH_BYTE;
                first_next = 1'b0;
                unique case (phase_reg)
                    PH_IND:
                    begin
                        res.out_byte     = (hdr_reg & h264fua_pkg::NRI_MASK)
                                           | h264fua_pkg::FU_A_TYPE;
                        res.packet_start = 1'b1;
                    end
                    PH_HDR:
                    begin
                        res.out_byte = fu_hdr;
                    end
                    default:
                    begin
                        res.packet_end = frag_end;
                        res.marker     = nal_end && last_reg;
                    end
                endcase
            end
            else
            begin
                res.packet_end = frag_end;
                res.marker     = nal_end && last_reg;
            end
            fill_next = frag_end ? '0 : fill_reg + PW'(1);
            if (nal_end)
            begin
                bp_next    = '0;
                frag_next  = 1'b0;
                first_next = 1'b1;
            end
            else
            begin
                bp_next = bp_reg + LB'(1);
            end
        end
    end

    assign res_valid = item_valid_reg && has_result;
    assign out_fire  = res_valid && res_ready;
    assign item_done = item_valid_reg && (!has_result || (out_fire && phase_reg == last_phase));
    assign nal.ready = !item_valid_reg || item_done;

    always_comb
    begin
        phase_next = phase_reg;
        if (item_done)
        begin
            phase_next = PH_IND;
        end
        else if (out_fire)
        begin
            unique case (phase_reg)
                PH_IND:
                begin
                    phase_next = PH_HDR;
                end
                default:
                begin
                    phase_next = PH_BYTE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            max_reg        <= h264fua_pkg::RESET_PAYLOAD;
            bp_reg         <= '0;
            total_reg      <= '0;
            frag_reg       <= 1'b0;
            fill_reg       <= '0;
            hdr_reg        <= '0;
            last_reg       <= 1'b0;
            first_reg      <= 1'b1;
            phase_reg      <= PH_IND;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= (cfg_wdata < h264fua_pkg::MIN_PAYLOAD) ?
                           h264fua_pkg::MIN_PAYLOAD : cfg_wdata;
            end
            if (nal.valid && nal.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            if (item_done)
            begin
                bp_reg    <= bp_next;
                total_reg <= total_next;
                frag_reg  <= frag_next;
                fill_reg  <= fill_next;
                hdr_reg   <= hdr_next;
                last_reg  <= last_next;
                first_reg <= first_next;
            end
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nal.valid && nal.ready)
        begin
            item_byte_reg <= nal.nal_byte;
            item_len_reg  <= nal.nal_length;
            item_last_reg <= nal.last_nal_in_unit;
            item_ts_reg   <= nal.timestamp;
        end
    end

    `H264FUA_ASSERT(a_phase_range, phase_reg <= PH_BYTE, "fragment header phase out of range")
    `H264FUA_ASSERT(a_phase_item, (phase_reg != PH_IND) |-> item_valid_reg, "header phase without a held word")
    `H264FUA_ASSERT(a_pos_in_nal, (bp_reg != '0) |-> (bp_reg < total_reg), "byte position beyond NAL length")
    `H264FUA_NEVER(a_fill_idle, !frag_reg && (fill_reg != '0), "fragment fill left over outside fragmentation")

endmodule

@@ design/h264fua_out_reg.sv @@
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer output register
// Holds one result word and presents it on the outgoing channel.
// ----------------------------------------------------------------------------
module h264fua_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  h264fua_pkg::res_t res,
    input  logic              res_valid,
    output logic              res_ready,
    h264fua_out_if.source     pkt
);

    logic              valid_reg;
    h264fua_pkg::res_t data_reg;

    // The register takes a new word when empty or when its word leaves.
    assign res_ready = !valid_reg || pkt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign pkt.valid            = valid_reg;
    assign pkt.out_byte         = data_reg.out_byte;
    assign pkt.packet_start     = data_reg.packet_start;
    assign pkt.packet_end       = data_reg.packet_end;
    assign pkt.marker           = data_reg.marker;
    assign pkt.packet_timestamp = data_reg.packet_timestamp;

endmodule

@@ tb/fua_payload_check.sv @@
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer payload check
// Watches the NAL and payload channels and the limit register port. Predicts
// every payload word from the accepted NAL words and compares each payload
// word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fua_payload_check (
    input  logic                          clk,
    input  logic                          rst_n,
    h264fua_in_if                         nal,
    h264fua_out_if                        pkt,
    input  logic                          cfg_we,
    input  logic [h264fua_pkg::PAY_W-1:0] cfg_wdata,
    output int                            mismatches,
    output int                            pending
);

    h264fua_pkg::res_t payload_q[$];

    logic [h264fua_pkg::PAY_W-1:0]  payload_limit;
    logic [h264fua_pkg::LEN_W-1:0]  nal_pos;
    logic [h264fua_pkg::LEN_W-1:0]  nal_total;
    logic                           in_fragments;
    logic [h264fua_pkg::LEN_W-1:0]  frag_fill;
    logic [h264fua_pkg::BYTE_W-1:0] saved_header;
    logic                           closes_unit;
    logic                           next_is_first;

    function automatic void queue_byte(input logic [h264fua_pkg::BYTE_W-1:0] b,
                                       input logic st, input logic en, input logic mk,
                                       input logic [h264fua_pkg::TS_W-1:0] ts);
        h264fua_pkg::res_t w;
        w.out_byte         = b;
        w.packet_start     = st;
        w.packet_end       = en;
        w.marker           = mk;
        w.packet_timestamp = ts;
        payload_q.insert(payload_q.size(), w);
    endfunction

    // Works out the payload words that one accepted NAL word gives.
    function automatic void predict_payload(input logic [h264fua_pkg::BYTE_W-1:0] b,
                                            input logic [h264fua_pkg::LEN_W-1:0] len,
                                            input logic last,
                                            input logic [h264fua_pkg::TS_W-1:0] ts);
        int                             cap;
        logic                           nal_end;
        logic                           frag_end;
        logic [h264fua_pkg::BYTE_W-1:0] fu_header;
        cap = int'(payload_limit) - 2;
        if (nal_pos == '0)
        begin
            // A word with zero length while awaiting a header is dropped.
            if (len != '0)
            begin
                nal_total   = len;
                closes_unit = last;
                if (len > payload_limit)
                begin
                    in_fragments  = 1'b1;
                    saved_header  = b;
                    next_is_first = 1'b1;
                    frag_fill     = '0;
                    nal_pos       = 16'd1;
                end
                else
                begin
                    in_fragments = 1'b0;
                    nal_end      = (len == 16'd1);
                    queue_byte(b, 1'b1, nal_end, nal_end && closes_unit, ts);
                    nal_pos = nal_end ? 16'd0 : 16'd1;
                end
            end
        end
        else if (!in_fragments)
        begin
            nal_end = (int'(nal_pos) + 1 >= int'(nal_total));
            queue_byte(b, 1'b0, nal_end, nal_end && closes_unit, ts);
            nal_pos = nal_end ? 16'd0 : nal_pos + 16'd1;
        end
        else
        begin
            nal_end = (int'(nal_pos) + 1 >= int'(nal_total));
            if (frag_fill == '0)
            begin
                // The E bit is judged against the limit in force right now.
                fu_header = saved_header & h264fua_pkg::TYPE_MASK;
                if (next_is_first)
                    fu_header = fu_header | h264fua_pkg::START_BIT;
                if (int'(nal_total) - int'(nal_pos) <= cap)
                    fu_header = fu_header | h264fua_pkg::END_BIT;
                queue_byte((saved_header & h264fua_pkg::NRI_MASK) | h264fua_pkg::FU_A_TYPE,
                           1'b1, 1'b0, 1'b0, ts);
                queue_byte(fu_header, 1'b0, 1'b0, 1'b0, ts);
                next_is_first = 1'b0;
            end
            frag_end = nal_end || (int'(frag_fill) + 1 >= cap);
            queue_byte(b, 1'b0, frag_end, nal_end && closes_unit, ts);
            frag_fill = frag_end ? 16'd0 : frag_fill + 16'd1;
            if (nal_end)
            begin
                nal_pos       = '0;
                in_fragments  = 1'b0;
                next_is_first = 1'b1;
            end
            else
            begin
                nal_pos = nal_pos + 16'd1;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        h264fua_pkg::res_t want;
        h264fua_pkg::res_t got;
        if (!rst_n)
        begin
            payload_q.delete();
            payload_limit = h264fua_pkg::RESET_PAYLOAD;
            nal_pos       = '0;
            nal_total     = '0;
            in_fragments  = 1'b0;
            frag_fill     = '0;
            saved_header  = '0;
            closes_unit   = 1'b0;
            next_is_first = 1'b1;
            mismatches    = 0;
            pending       = 0;
        end
        else
        begin
            if (cfg_we)
                payload_limit = (cfg_wdata < h264fua_pkg::MIN_PAYLOAD) ?
                                h264fua_pkg::MIN_PAYLOAD : cfg_wdata;
            if (nal.valid && nal.ready)
                predict_payload(nal.nal_byte, nal.nal_length, nal.last_nal_in_unit,
                                nal.timestamp);
            if (pkt.valid && pkt.ready)
            begin
                got.out_byte         = pkt.out_byte;
                got.packet_start     = pkt.packet_start;
                got.packet_end       = pkt.packet_end;
                got.marker           = pkt.marker;
                got.packet_timestamp = pkt.packet_timestamp;
                if (payload_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, got %h %b %b %b %h",
                             $time, got.out_byte, got.packet_start, got.packet_end,
                             got.marker, got.packet_timestamp);
                end
                else
                begin
                    want = payload_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch, expected byte %h st %b end %b mk %b ts %h",
                                 $time, want.out_byte, want.packet_start, want.packet_end,
                                 want.marker, want.packet_timestamp);
                        $display("%0t: mismatch, got      byte %h st %b end %b mk %b ts %h",
                                 $time, got.out_byte, got.packet_start, got.packet_end,
                                 got.marker, got.packet_timestamp);
                    end
                end
            end
            pending = payload_q.size();
        end
    end

endmodule

@@ tb/tb_h264_rtp_fu_a_packetizer.sv @@
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer testbench
// Feeds NAL units word by word: a directed opening on the edge cases, then
// random NAL units under a range of payload limits and three idling mixes,
// with a short pass-through run at the largest limit. A payload check beside
// the block predicts and compares every payload word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_h264_rtp_fu_a_packetizer;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 4;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [h264fua_pkg::PAY_W-1:0] cfg_wdata;

    int send_idle_pct = 7;
    int recv_idle_pct = 51;
    int words_sent    = 0;
    int limit_now     = 1400;
    int mismatches;
    int pending;
    int cycle_count;

    h264fua_in_if  nal_ch();
    h264fua_out_if pkt_ch();

    h264_rtp_fu_a_packetizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .nal       (nal_ch),
        .pkt       (pkt_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    fua_payload_check payload_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .nal        (nal_ch),
        .pkt        (pkt_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        pkt_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            pkt_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(input logic [h264fua_pkg::BYTE_W-1:0] b,
                             input logic [h264fua_pkg::LEN_W-1:0] len,
                             input logic last, input logic [h264fua_pkg::TS_W-1:0] ts);
        logic took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            nal_ch.valid <= 1'b0;
            @(posedge clk);
        end
        nal_ch.valid            <= 1'b1;
        nal_ch.nal_byte         <= b;
        nal_ch.nal_length       <= len;
        nal_ch.last_nal_in_unit <= last;
        nal_ch.timestamp        <= ts;
        // Ready is sampled at the falling edge, once everything has settled.
        do
        begin
            @(negedge clk);
            took = nal_ch.ready;
            @(posedge clk);
        end
        while (!took);
        words_sent++;
    endtask

    // A body word: its length and flag are ignored by the block, so they are noise.
    task automatic send_data();
        send_word(h264fua_pkg::BYTE_W'($urandom_range(255)), h264fua_pkg::LEN_W'($urandom()),
                  1'($urandom_range(1)), $urandom());
    endtask

    task automatic send_nal(input int len, input logic [h264fua_pkg::BYTE_W-1:0] header,
                            input logic last);
        send_word(header, h264fua_pkg::LEN_W'(len), last, $urandom());
        for (int i = 1; i < len; i++)
            send_data();
    endtask

    task automatic settle();
        nal_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [h264fua_pkg::PAY_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        limit_now = (v < h264fua_pkg::MIN_PAYLOAD) ? int'(h264fua_pkg::MIN_PAYLOAD) : int'(v);
    endtask

    function automatic logic [h264fua_pkg::PAY_W-1:0] pick_limit();
        unique case ($urandom_range(9))
            0:       return h264fua_pkg::PAY_W'($urandom_range(3));
            1:       return h264fua_pkg::PAY_W'($urandom_range(65535));
            default: return h264fua_pkg::PAY_W'($urandom_range(4, 16));
        endcase
    endfunction

    // For limits up to 40, lengths cluster around the limit so that
    // pass-through and fragment boundaries are hit often.
    function automatic int pick_length(input int lim);
        if (lim > 40)
            return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
        unique case ($urandom_range(7))
            0:       return 0;
            1:       return 1;
            2:       return lim;
            3:       return lim + 1;
            4:       return 2 * (lim - 2) + 1;
            default: return $urandom_range(1, 3 * lim);
        endcase
    endfunction

    task automatic run_random(input int count);
        int target;
        int next_cfg;
        int max_len;
        target   = words_sent + count;
        next_cfg = words_sent + $urandom_range(30, 60);
        while (words_sent < target)
        begin
            if (words_sent >= next_cfg)
            begin
                settle();
                write_limit(pick_limit());
                next_cfg = words_sent + $urandom_range(30, 60);
            end
            if ($urandom_range(11) == 0)
            begin
                // A stray header word whose declared length is never honored.
                max_len = (limit_now > 40) ? 40 : 3 * limit_now;
                send_word(h264fua_pkg::BYTE_W'($urandom_range(255)),
                          h264fua_pkg::LEN_W'($urandom_range(max_len)),
                          1'($urandom_range(1)), $urandom());
            end
            else
            begin
                send_nal(pick_length(limit_now), h264fua_pkg::BYTE_W'($urandom_range(255)),
                         1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        nal_ch.valid            = 1'b0;
        nal_ch.nal_byte         = '0;
        nal_ch.nal_length       = '0;
        nal_ch.last_nal_in_unit = 1'b0;
        nal_ch.timestamp        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset limit, then 4: empty, one-byte and short NALs.
        send_word(8'hFF, 16'd0, 1'b1, 32'hFFFF_FFFF);
        send_nal(1, 8'h00, 1'b1);
        send_nal(2, 8'hFF, 1'b0);
        settle();
        write_limit(16'd0);
        send_nal(4, 8'h65, 1'b1);
        send_nal(5, 8'hFF, 1'b1);

        // The limit moves in the middle of a fragmented NAL.
        send_word(8'h5C, 16'd9, 1'b1, 32'h0000_0000);
        repeat (3) send_data();
        settle();
        write_limit(16'd6);
        repeat (5) send_data();
        settle();
        write_limit(16'd3);

        run_random(125);

        settle();
        send_idle_pct = 51;
        recv_idle_pct = 7;
        write_limit(pick_limit());
        run_random(125);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(16'hFFFF);
        send_nal(3, h264fua_pkg::BYTE_W'($urandom_range(255)), 1'b0);
        send_nal(20, h264fua_pkg::BYTE_W'($urandom_range(255)), 1'b1);
        settle();
        write_limit(pick_limit());
        run_random(125);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/h264fua_pkg.sv
design/h264fua_if.sv
design/h264fua_core.sv
design/h264fua_out_reg.sv
design/h264_rtp_fu_a_packetizer.sv
tb/fua_payload_check.sv
tb/tb_h264_rtp_fu_a_packetizer.sv
